// ----- sv/sofc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofc_pkg
// shared widths, register codes, command types and rounding helpers for the
// second-order complementary filter
// ----------------------------------------------------------------------------
package sofc_pkg;

    localparam int DATA_W     = 32;   // Q16.16 sample and state width
    localparam int WK_W       = 16;   // weight k, Q0.16
    localparam int DT_W       = 24;   // step time, Q0.24
    localparam int Q_FRAC     = 16;
    localparam int DT_FRAC    = 24;
    localparam int OMK_W      = 17;   // 1 - k, range 1 .. 65536
    localparam int ERR_W      = 33;
    localparam int C1_W       = 17;
    localparam int X1_W       = 34;
    localparam int X2_W       = 35;
    localparam int RATE_W     = 37;
    localparam int SUM_W      = 36;   // state update before clamping
    localparam int MA_W       = 37;   // multiplier operand a, signed
    localparam int MB_W       = 26;   // multiplier operand b, signed
    localparam int PROD_W     = MA_W + MB_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_K  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 1'd1;

    localparam logic [WK_W-1:0]  WEIGHT_K_RESET  = 16'd13107;
    localparam logic [DT_W-1:0]  STEP_TIME_RESET = 24'd251658;
    localparam logic [OMK_W-1:0] OMK_ONE         = 17'h10000;

    // operand pair routed into the shared multiplier
    typedef enum logic [2:0] {
        MS_OMK_OMK  = 3'd0,
        MS_ERR_2OMK = 3'd1,
        MS_ERR_C1   = 3'd2,
        MS_X1_DT    = 3'd3,
        MS_RATE_DT  = 3'd4
    } sofc_mul_sel_t;

    typedef struct packed {
        logic          load;       // take sample, form error
        sofc_mul_sel_t mul_sel;
        logic          c1_en;
        logic          x2_en;
        logic          x1_en;
        logic          integ_en;
        logic          rate_en;
        logic          angle_en;   // update estimate and load output
    } sofc_cmd_t;

    typedef struct packed {
        logic out_free;
    } sofc_sts_t;

    // round half up, then arithmetic shift right
    function automatic logic signed [PROD_W-1:0] round_shr(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [SUM_W-1:0] v
    );
        if (v > $signed({{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}))
            return $signed({1'b0, {(DATA_W-1){1'b1}}});
        else if (v < $signed({{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
            return $signed({1'b1, {(DATA_W-1){1'b0}}});
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ----- sv/sofc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofc stream interfaces
// valid/ready channels for samples in and angle estimates out
// ----------------------------------------------------------------------------
interface sofc_in_if import sofc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] accel_angle;
    logic signed [DATA_W-1:0] gyro_rate;

    modport source (output valid, output accel_angle, output gyro_rate, input ready);
    modport sink   (input valid, input accel_angle, input gyro_rate, output ready);
endinterface

interface sofc_out_if import sofc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] angle_estimate;

    modport source (output valid, output angle_estimate, input ready);
    modport sink   (input valid, input angle_estimate, output ready);
endinterface

// ----- sv/sofc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofc_ctrl
// sequencer that steps one sample through the shared multiplier schedule
// ----------------------------------------------------------------------------
module sofc_ctrl import sofc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sofc_sts_t sts,
    output sofc_cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_C1   = 10'b00_0000_0010,
        S_X2   = 10'b00_0000_0100,
        S_X1   = 10'b00_0000_1000,
        S_RX1  = 10'b00_0001_0000,
        S_MI   = 10'b00_0010_0000,
        S_UI   = 10'b00_0100_0000,
        S_RATE = 10'b00_1000_0000,
        S_MF   = 10'b01_0000_0000,
        S_UF   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                cmd.mul_sel = MS_OMK_OMK;
                state_next  = S_X2;
            end
            S_X2:
            begin
                cmd.mul_sel = MS_ERR_2OMK;
                cmd.c1_en   = 1'b1;
                state_next  = S_X1;
            end
            S_X1:
            begin
                cmd.mul_sel = MS_ERR_C1;
                cmd.x2_en   = 1'b1;
                state_next  = S_RX1;
            end
            S_RX1:
            begin
                cmd.x1_en  = 1'b1;
                state_next = S_MI;
            end
            S_MI:
            begin
                cmd.mul_sel = MS_X1_DT;
                state_next  = S_UI;
            end
            S_UI:
            begin
                cmd.integ_en = 1'b1;
                state_next   = S_RATE;
            end
            S_RATE:
            begin
                cmd.rate_en = 1'b1;
                state_next  = S_MF;
            end
            S_MF:
            begin
                cmd.mul_sel = MS_RATE_DT;
                state_next  = S_UF;
            end
            S_UF:
            begin
                // hold the product steady while the output slot is busy
                cmd.mul_sel = MS_RATE_DT;
                if (sts.out_free)
                begin
                    cmd.angle_en = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/sofc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sofc_datapath
// filter state, shared multiplier, rounding, clamping and output register
// ----------------------------------------------------------------------------
module sofc_datapath import sofc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sofc_cmd_t                cmd,
    output sofc_sts_t                sts,
    input  logic signed [DATA_W-1:0] accel_angle,
    input  logic signed [DATA_W-1:0] gyro_rate,
    input  logic [WK_W-1:0]          weight_k,
    input  logic [DT_W-1:0]          step_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] angle_estimate
);

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DATA_W-1:0] gyro_reg;
    logic [C1_W-1:0]          c1_reg;
    logic signed [X2_W-1:0]   x2_reg;
    logic signed [X1_W-1:0]   x1_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] angle_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_valid_reg;

    logic [OMK_W-1:0]         omk;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] rnd_q;
    logic signed [PROD_W-1:0] rnd_dt;
    logic signed [SUM_W-1:0]  integ_sum;
    logic signed [SUM_W-1:0]  angle_sum;
    logic signed [DATA_W-1:0] angle_next;

    assign omk = OMK_ONE - {1'b0, weight_k};

    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_OMK_OMK:
            begin
                mul_a = $signed({{(MA_W-OMK_W){1'b0}}, omk});
                mul_b = $signed({{(MB_W-OMK_W){1'b0}}, omk});
            end
            MS_ERR_2OMK:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = $signed({{(MB_W-OMK_W-1){1'b0}}, omk, 1'b0});
            end
            MS_ERR_C1:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = $signed({{(MB_W-C1_W){1'b0}}, c1_reg});
            end
            MS_X1_DT:
            begin
                mul_a = MA_W'(x1_reg);
                mul_b = $signed({{(MB_W-DT_W){1'b0}}, step_time});
            end
            MS_RATE_DT:
            begin
                mul_a = rate_reg;
                mul_b = $signed({{(MB_W-DT_W){1'b0}}, step_time});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd_q      = round_shr(prod_reg, Q_FRAC);
    assign rnd_dt     = round_shr(prod_reg, DT_FRAC);
    assign integ_sum  = SUM_W'(integ_reg) + SUM_W'(rnd_dt);
    assign angle_sum  = SUM_W'(angle_reg) + SUM_W'(rnd_dt);
    assign angle_next = sat32(angle_sum);

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            err_reg  <= ERR_W'(accel_angle) - ERR_W'(angle_reg);
            gyro_reg <= gyro_rate;
        end
        if (cmd.c1_en)
            c1_reg <= rnd_q[C1_W-1:0];
        if (cmd.x2_en)
            x2_reg <= rnd_q[X2_W-1:0];
        if (cmd.x1_en)
            x1_reg <= rnd_q[X1_W-1:0];
        if (cmd.rate_en)
            rate_reg <= RATE_W'(integ_reg) + RATE_W'(x2_reg) + RATE_W'(gyro_reg);
        if (cmd.angle_en)
            out_data_reg <= angle_next;
    end

    // filter state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.integ_en)
                integ_reg <= sat32(integ_sum);
            if (cmd.angle_en)
            begin
                angle_reg     <= angle_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign angle_estimate  = out_data_reg;

endmodule

// ----- sv/second_order_complementary_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_complementary_filter_core
// one-axis tilt fusion of accelerometer angle and gyroscope rate
// ----------------------------------------------------------------------------
// Each sample transaction (accelerometer angle and gyro rate, signed Q16.16)
// yields one angle estimate transaction, signed Q16.16, clamped to the 32-bit
// range. The error is formed at the edge that accepts the sample, and the
// estimate is registered at the output after a schedule of steps through the
// single shared 37x26 multiplier, which computes five products in turn
// ((1-k)^2, 2(1-k)*err, err*c1, x1*dt, rate*dt), each registered and rounded
// before the next use. The sequencer is back in idle at the edge that
// registers the estimate. One sample is in flight at a time; a new sample is
// taken as soon as the previous estimate has been written to the output
// register, even if that estimate is still waiting to be taken. The last step
// of the schedule stalls while an earlier estimate still sits untaken in the
// output register. weight_k (index 0) and step_time (index 1) are written
// through the configuration port; the user must write them only while no
// sample is in flight, as the core itself does not enforce this.
// ----------------------------------------------------------------------------
module second_order_complementary_filter_core import sofc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    sofc_in_if.sink               sample,
    sofc_out_if.source            result,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [WK_W-1:0] weight_k_reg;
    logic [DT_W-1:0] step_time_reg;

    sofc_cmd_t cmd;
    sofc_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_k_reg  <= WEIGHT_K_RESET;
            step_time_reg <= STEP_TIME_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_WEIGHT_K:  weight_k_reg  <= cfg_data[WK_W-1:0];
                REG_STEP_TIME: step_time_reg <= cfg_data[DT_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer: issues one command word per cycle
    sofc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, filter state and output register
    sofc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .accel_angle    (sample.accel_angle),
        .gyro_rate      (sample.gyro_rate),
        .weight_k       (weight_k_reg),
        .step_time      (step_time_reg),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .angle_estimate (result.angle_estimate)
    );

    // a sample is never taken back to back: the sequencer goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample accepted while previous transaction in flight");

    // the estimate is only committed when the output slot can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.angle_en |-> (!result.valid || result.ready))
        else $error("estimate committed over a pending result");

    // a committed estimate shows up at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.angle_en |=> result.valid)
        else $error("committed estimate missing at output");

    // the input is only taken when the sequencer issues a load
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |-> cmd.load)
        else $error("sample accepted without load command");

endmodule

// ----- verif/second_order_complementary_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_order_complementary_filter_core_tb
// self-checking bench for the one-axis tilt fusion core: a queue-fed driver
// pushes sample transactions with random gaps, a bit-exact fixed-point fusion
// predictor forms the expected angle estimates, and a monitor with random
// back-pressure compares every estimate transaction in order
// ----------------------------------------------------------------------------
module second_order_complementary_filter_core_tb;
    import sofc_pkg::*;

    // idle share of each side, in percent
    localparam int IDLE_PCT = 30;
    // cycles with no transaction on either channel before giving up
    localparam int WATCHDOG_LIMIT = 5000;
    // spare cycles after the last estimate before touching registers or ending
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    localparam longint ONE_DEG = 65536;
    localparam longint Q_MAX   = 64'sd2147483647;
    localparam longint Q_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel;
        logic signed [DATA_W-1:0] gyro;
    } sample_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sofc_in_if  sample_ch ();
    sofc_out_if result_ch ();

    second_order_complementary_filter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample_ch),
        .result       (result_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // samples waiting for the driver, estimates waiting for the monitor
    sample_t                  sample_q[$];
    logic signed [DATA_W-1:0] estimate_q[$];
    sample_t                  drive_item;

    // predictor copy of the registers and the filter state
    logic [WK_W-1:0] weight_q = WEIGHT_K_RESET;
    logic [DT_W-1:0] dt_q     = STEP_TIME_RESET;
    longint          fused_q  = 0;
    longint          integ_q  = 0;

    // slowly moving true tilt used to build plausible sample streams
    longint track_angle = 0;

    int sent_count = 0;
    int done_count = 0;
    int fail_count = 0;
    int quiet_cycles;
    bit steady;

    // 12 ns clock, starts low so the first edge sees reset already low
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // fixed-point fusion predictor
    // ------------------------------------------------------------------------

    // add half an lsb, then floor-shift (arithmetic shift floors)
    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_q16(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // advances the predictor state by one sample and returns the new estimate
    function automatic logic signed [DATA_W-1:0] fuse_sample(
        input logic signed [DATA_W-1:0] accel,
        input logic signed [DATA_W-1:0] gyro
    );
        longint omk;
        longint dt;
        longint err;
        longint c1;
        longint x1;
        longint x2;
        longint rate;
        // 1 - k, exactly one when the weight is zero
        omk = 65536 - longint'(weight_q);
        dt = longint'(dt_q);
        err = longint'(accel) - fused_q;
        c1 = rnd_shift(omk * omk, 16);
        x1 = rnd_shift(err * c1, 16);
        // integrator takes err*(1-k)^2*dt and clamps
        integ_q = clamp_q16(integ_q + rnd_shift(x1 * dt, DT_FRAC));
        x2 = rnd_shift(2 * omk * err, 16);
        // rate is kept wide, only the state update clamps
        rate = integ_q + x2 + longint'(gyro);
        fused_q = clamp_q16(fused_q + rnd_shift(rate * dt, DT_FRAC));
        return fused_q[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // sample driver: feeds the queue into the input channel with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid       <= 1'b0;
            sample_ch.accel_angle <= '0;
            sample_ch.gyro_rate   <= '0;
        end
        else
        begin
            // an accepted sample transaction moves the predictor one step
            if (sample_ch.valid && sample_ch.ready)
                estimate_q.push_back(fuse_sample(sample_ch.accel_angle,
                                                 sample_ch.gyro_rate));
            // offer a new sample only once the current one is gone
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    drive_item = sample_q.pop_front();
                    sample_ch.valid       <= 1'b1;
                    sample_ch.accel_angle <= drive_item.accel;
                    sample_ch.gyro_rate   <= drive_item.gyro;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // estimate monitor: random back-pressure, in-order compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (estimate_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected estimate transaction: actual %0d",
                                 result_ch.angle_estimate);
                    fail_count++;
                end
                else
                begin
                    if (result_ch.angle_estimate !== estimate_q[0])
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("angle_estimate mismatch #%0d: expected %0d actual %0d",
                                     done_count, estimate_q[0], result_ch.angle_estimate);
                        fail_count++;
                    end
                    void'(estimate_q.pop_front());
                    done_count++;
                end
            end
            result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when neither channel moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("second_order_complementary_filter_core_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_sample(input longint accel, input longint gyro);
        sample_t item;
        item.accel = accel[DATA_W-1:0];
        item.gyro  = gyro[DATA_W-1:0];
        sample_q.push_back(item);
        sent_count++;
    endtask

    // wait until every queued sample has come back as an estimate
    task automatic wait_drained;
        while (done_count != sent_count)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // registers change only with the core idle
    task automatic configure(input longint wk, input longint dt);
        wait_drained();
        write_reg(REG_WEIGHT_K, wk);
        write_reg(REG_STEP_TIME, dt);
        weight_q = wk[WK_W-1:0];
        dt_q     = dt[DT_W-1:0];
    endtask

    // mostly values near a center, some full-range noise, tiny values, extremes
    function automatic longint pick_value(input longint center, input longint spread);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return clamp_q16(center + longint'($urandom_range(0, 2 * spread)) - spread);
        if (sel < 85)
            return longint'($signed($urandom));
        if (sel < 93)
            return longint'($urandom_range(0, 128)) - 64;
        case ($urandom_range(0, 3))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // a tilt that wanders within +-90 degrees, seen through noisy sensors
    task automatic queue_tracking(input int count, input bit calm);
        int i;
        steady <= calm;
        for (i = 0; i < count; i++)
        begin
            track_angle = track_angle + longint'($urandom_range(0, 4 * ONE_DEG)) - 2 * ONE_DEG;
            if (track_angle > 90 * ONE_DEG)
                track_angle = 90 * ONE_DEG;
            else if (track_angle < -90 * ONE_DEG)
                track_angle = -90 * ONE_DEG;
            queue_sample(pick_value(track_angle, 5 * ONE_DEG), pick_value(0, 250 * ONE_DEG));
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_WEIGHT_K;
        cfg_data     <= '0;
        steady       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values, field extremes
        queue_sample(0, 0);
        queue_sample(Q_MAX, 0);
        queue_sample(Q_MIN, 0);
        queue_sample(0, Q_MAX);
        queue_sample(0, Q_MIN);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample(-1, 1);

        // weight zero with the longest step: drives both states into the clamps
        configure(0, 24'hFFFFFF);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample(0, 0);
        queue_sample(0, 0);

        // step time zero: state must hold whatever the inputs
        configure(16'hFFFF, 0);
        queue_sample(Q_MAX, Q_MIN);
        queue_sample(123, -456);
        queue_sample(Q_MIN, Q_MAX);

        // largest weight, smallest nonzero step
        configure(16'hFFFF, 1);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MIN, Q_MIN);

        // random part: nominal settings with no idling, then a spread of settings
        configure(WEIGHT_K_RESET, STEP_TIME_RESET);
        queue_tracking(120, 1'b1);
        configure($urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
        queue_tracking(80, 1'b0);
        configure(0, $urandom_range(0, 24'h0FFFFF));
        queue_tracking(60, 1'b0);
        configure(16'hFFFF, 24'hFFFFFF);
        queue_tracking(40, 1'b0);
        configure($urandom_range(0, 65535), 0);
        queue_tracking(20, 1'b0);
        configure($urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF));
        queue_tracking(80, 1'b0);

        wait_drained();
        if (fail_count == 0 && estimate_q.size() == 0)
            $display("second_order_complementary_filter_core_tb: PASS");
        else
            $display("second_order_complementary_filter_core_tb: FAIL");
        $finish;
    end

endmodule
